### src/clci_pkg.sv
// Shared types, codes and constants of the cubed-Lorentzian density/integral block.
// Depends on nothing; the CORDIC cell, the lane, the top level and the checker import it.
package clci_pkg;

    typedef enum logic [1:0] {
        FUNC_DENSITY  = 2'd0,
        FUNC_INTEGRAL = 2'd1,
        FUNC_RANGE    = 2'd2
    } func_t;

    localparam logic [1:0] REG_CENTER     = 2'd0;
    localparam logic [1:0] REG_SCALE_K    = 2'd1;
    localparam logic [1:0] REG_RANGE_LOW  = 2'd2;
    localparam logic [1:0] REG_RANGE_HIGH = 2'd3;

    localparam logic [31:0] SCALE_K_RESET = 32'h0100_0000;

    localparam int UW   = 33;   // offset from center
    localparam int TW   = 57;   // t, Q.32
    localparam int WDW  = 63;   // divisor of the w row
    localparam int WQW  = 31;   // w, Q.30
    localparam int HQW  = 40;   // h, Q.30
    localparam int CXW  = 60;   // CORDIC x/y
    localparam int CZW  = 34;   // CORDIC angle
    localparam int IW   = 45;   // signed integral, Q29.16
    localparam int DW   = 17;   // density, Q1.16

    localparam logic [31:0] ATAN_TAB [11] = '{
        32'h3243F6A9, 32'h1DAC6705, 32'h0FADBAFD, 32'h07F56EA7, 32'h03FEAB77,
        32'h01FFD55C, 32'h00FFFAAB, 32'h007FFF55, 32'h003FFFEB, 32'h001FFFFD,
        32'h00100000
    };

    function automatic logic [31:0] atan_angle(input int idx);
        logic [31:0] ang;
        if (idx <= 10)
        begin
            ang = ATAN_TAB[idx[3:0]];
        end
        else
        begin
            ang = 32'h4000_0000 >> idx;
        end
        return ang;
    endfunction

    typedef struct packed {
        logic signed [IW-1:0] integral;
        logic [DW-1:0]        density;
    } lane_out_t;

endpackage

### src/clci_div_cell.sv
// One restoring-division cell: settles one quotient bit and hands the rest on.
// Depends on nothing.
module clci_div_cell #(
    parameter int RW = 63,
    parameter int FW = 1,
    parameter int QW = 31
) (
    input  logic          clk,
    input  logic [RW-1:0] rem_in,
    input  logic [RW-1:0] div_in,
    input  logic [FW-1:0] feed_in,
    input  logic [QW-1:0] q_in,
    output logic [RW-1:0] rem_out,
    output logic [RW-1:0] div_out,
    output logic [FW-1:0] feed_out,
    output logic [QW-1:0] q_out
);
    logic [RW:0]   trial;
    logic [RW:0]   diff;
    logic          ge;
    logic [RW-1:0] rem_reg, rem_next;
    logic [RW-1:0] div_reg;
    logic [FW-1:0] feed_reg;
    logic [QW-1:0] q_reg;

    always_comb
    begin
        trial    = {rem_in, feed_in[FW-1]};
        diff     = trial - {1'b0, div_in};
        ge       = (trial >= {1'b0, div_in});
        rem_next = ge ? diff[RW-1:0] : trial[RW-1:0];
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        div_reg  <= div_in;
        feed_reg <= feed_in << 1;
        q_reg    <= {q_in[QW-2:0], ge};
    end

    assign rem_out  = rem_reg;
    assign div_out  = div_reg;
    assign feed_out = feed_reg;
    assign q_out    = q_reg;
endmodule

### src/clci_cordic_cell.sv
// One vectoring CORDIC cell: rotates toward the x axis and accumulates the angle.
// Depends on clci_pkg for widths and the angle table.
module clci_cordic_cell
    import clci_pkg::*;
#(
    parameter int IDX = 0
) (
    input  logic                  clk,
    input  logic signed [CXW-1:0] x_in,
    input  logic signed [CXW-1:0] y_in,
    input  logic signed [CZW-1:0] z_in,
    output logic signed [CXW-1:0] x_out,
    output logic signed [CXW-1:0] y_out,
    output logic signed [CZW-1:0] z_out
);
    localparam logic signed [CZW-1:0] ANG = CZW'(atan_angle(IDX));

    logic signed [CXW-1:0] x_reg, x_next;
    logic signed [CXW-1:0] y_reg, y_next;
    logic signed [CZW-1:0] z_reg, z_next;
    logic signed [CXW-1:0] dx;
    logic signed [CXW-1:0] dy;

    always_comb
    begin
        dx = y_in >>> IDX;
        dy = x_in >>> IDX;
        if (y_in > 0)
        begin
            x_next = x_in + dx;
            y_next = y_in - dy;
            z_next = z_in + ANG;
        end
        else
        begin
            x_next = x_in - dx;
            y_next = y_in + dy;
            z_next = z_in - ANG;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
    end

    assign x_out = x_reg;
    assign y_out = y_reg;
    assign z_out = z_reg;
endmodule

### src/clci_delay.sv
// Row of shift cells that holds side data beside the arithmetic rows.
// Depends on nothing.
module clci_delay #(
    parameter int W     = 8,
    parameter int DEPTH = 4
) (
    input  logic         clk,
    input  logic [W-1:0] din,
    output logic [W-1:0] dout
);
    logic [W-1:0] stage_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        stage_reg[0] <= din;
        for (int i = 1; i < DEPTH; i++)
        begin
            stage_reg[i] <= stage_reg[i-1];
        end
    end

    assign dout = stage_reg[DEPTH-1];
endmodule

### src/clci_lane.sv
// One evaluation lane: density and integral at one offset u, fully pipelined.
// Depends on clci_pkg, clci_div_cell, clci_cordic_cell and clci_delay.
module clci_lane
    import clci_pkg::*;
#(
    parameter int ATAN_STAGES = 24
) (
    input  logic                 clk,
    input  logic signed [UW-1:0] u,
    input  logic [31:0]          scale_k,
    output lane_out_t            result
);
    localparam int D_SIDE = ATAN_STAGES + 41;
    localparam int D_HS   = ATAN_STAGES + 38;
    localparam int D_FD   = ATAN_STAGES + 5;
    localparam int D_T    = ATAN_STAGES + 1;
    localparam int SIDEW  = UW + 2;
    localparam int FW_F   = 33;

    // magnitude and t
    logic [UW-1:0] umag_reg, umag_next;
    logic          neg_reg;
    logic [64:0]   prod;
    logic [TW-1:0] t_reg, t_next;
    logic [SIDEW-1:0] side_reg, side_m;

    always_comb
    begin
        umag_next = u[UW-1] ? UW'(-u) : UW'(u);
        prod      = 65'(umag_reg) * 65'(scale_k);
        t_next    = prod[64:8];
    end

    always_ff @(posedge clk)
    begin
        umag_reg <= umag_next;
        neg_reg  <= u[UW-1];
        t_reg    <= t_next;
        side_reg <= {umag_reg, neg_reg, (t_next[TW-1:24] == '0)};
    end

    // t squared, Q.32
    logic [49:0] p_hh_reg;
    logic [56:0] p_hl_reg;
    logic [63:0] p_ll_reg;
    logic        tbig_reg;
    logic [63:0] t2_sum;
    logic [WDW-1:0] wd_reg, wd_next;
    logic [15:0] t2_reg;
    logic [WQW-1:0] hs_reg, hs_next;
    logic [30:0] hs_prod;

    always_comb
    begin
        t2_sum  = (64'(p_hh_reg) << 32) + (64'(p_hl_reg) << 1) + (p_ll_reg >> 32);
        wd_next = tbig_reg ? '1 : (WDW'(64'h1_0000_0000) + t2_sum[WDW-1:0]);
        hs_prod = 31'(t2_reg[15:2]) * 31'(17'd43691);
        hs_next = WQW'(32'h4000_0000) - WQW'(hs_prod >> 17);
    end

    always_ff @(posedge clk)
    begin
        p_hh_reg <= t_reg[56:32] * t_reg[56:32];
        p_hl_reg <= t_reg[56:32] * t_reg[31:0];
        p_ll_reg <= t_reg[31:0] * t_reg[31:0];
        tbig_reg <= (t_reg[TW-1:47] != '0);
        wd_reg   <= wd_next;
        t2_reg   <= t2_sum[15:0];
        hs_reg   <= hs_next;
    end

    // w = 2^62 / (2^32 + t^2)
    logic [WDW-1:0] wr [WQW+1];
    logic [WDW-1:0] wdv [WQW+1];
    logic [0:0]     wf [WQW+1];
    logic [WQW-1:0] wq [WQW+1];

    assign wr[0]  = WDW'(64'h8000_0000);
    assign wdv[0] = wd_reg;
    assign wf[0]  = 1'b0;
    assign wq[0]  = '0;

    for (genvar i = 0; i < WQW; i++)
    begin : g_wdiv
        clci_div_cell #(.RW(WDW), .FW(1), .QW(WQW)) u_cell (
            .clk      (clk),
            .rem_in   (wr[i]),
            .div_in   (wdv[i]),
            .feed_in  (wf[i]),
            .q_in     (wq[i]),
            .rem_out  (wr[i+1]),
            .div_out  (wdv[i+1]),
            .feed_out (wf[i+1]),
            .q_out    (wq[i+1])
        );
    end

    // density and F
    logic [61:0]    ww_reg;
    logic [WQW-1:0] w1_reg;
    logic [FW_F-1:0] f_reg, f2_reg;
    logic [61:0]    w3_reg;
    logic [DW-1:0]  dens_reg;
    logic [32:0]    w3_round;

    assign w3_round = 33'(w3_reg[61:30]) + 33'h2000;

    always_ff @(posedge clk)
    begin
        ww_reg   <= 62'(wq[WQW]) * 62'(wq[WQW]);
        w1_reg   <= wq[WQW];
        f_reg    <= (FW_F'(w1_reg) * FW_F'(3)) + FW_F'(ww_reg >> 29);
        w3_reg   <= 62'(ww_reg[60:30]) * 62'(w1_reg);
        f2_reg   <= f_reg;
        dens_reg <= DW'(w3_round >> 14);
    end

    // atan(t) by CORDIC
    logic signed [CXW-1:0] cx [ATAN_STAGES+1];
    logic signed [CXW-1:0] cy [ATAN_STAGES+1];
    logic signed [CZW-1:0] cz [ATAN_STAGES+1];

    assign cx[0] = CXW'(64'h1_0000_0000);
    assign cy[0] = CXW'(t_reg);
    assign cz[0] = '0;

    for (genvar i = 0; i < ATAN_STAGES; i++)
    begin : g_cordic
        clci_cordic_cell #(.IDX(i)) u_cell (
            .clk   (clk),
            .x_in  (cx[i]),
            .y_in  (cy[i]),
            .z_in  (cz[i]),
            .x_out (cx[i+1]),
            .y_out (cy[i+1]),
            .z_out (cz[i+1])
        );
    end

    logic [30:0]   a_reg;
    logic [TW-1:0] t_d;

    always_ff @(posedge clk)
    begin
        a_reg <= cz[ATAN_STAGES][CZW-1] ? '0 : cz[ATAN_STAGES][30:0];
    end

    clci_delay #(.W(TW), .DEPTH(D_T)) u_dly_t (
        .clk  (clk),
        .din  (t_reg),
        .dout (t_d)
    );

    // h = atan(t) * 2^32 / t
    logic [TW-1:0]  hr [HQW+1];
    logic [TW-1:0]  hdv [HQW+1];
    logic [7:0]     hf [HQW+1];
    logic [HQW-1:0] hq [HQW+1];

    assign hr[0]  = TW'(a_reg[30:8]);
    assign hdv[0] = t_d;
    assign hf[0]  = a_reg[7:0];
    assign hq[0]  = '0;

    for (genvar i = 0; i < HQW; i++)
    begin : g_hdiv
        clci_div_cell #(.RW(TW), .FW(8), .QW(HQW)) u_cell (
            .clk      (clk),
            .rem_in   (hr[i]),
            .div_in   (hdv[i]),
            .feed_in  (hf[i]),
            .q_in     (hq[i]),
            .rem_out  (hr[i+1]),
            .div_out  (hdv[i+1]),
            .feed_out (hf[i+1]),
            .q_out    (hq[i+1])
        );
    end

    // align side data with h
    logic [WQW-1:0]       hs_m;
    logic [FW_F+DW-1:0]   fd_m;

    clci_delay #(.W(SIDEW), .DEPTH(D_SIDE)) u_dly_side (
        .clk  (clk),
        .din  (side_reg),
        .dout (side_m)
    );

    clci_delay #(.W(WQW), .DEPTH(D_HS)) u_dly_hs (
        .clk  (clk),
        .din  (hs_reg),
        .dout (hs_m)
    );

    clci_delay #(.W(FW_F + DW), .DEPTH(D_FD)) u_dly_fd (
        .clk  (clk),
        .din  ({f2_reg, dens_reg}),
        .dout (fd_m)
    );

    // S, product with |u|, sign
    logic [HQW-1:0] h_sel;
    logic [42:0]    s_sum;
    logic [40:0]    s_reg;
    logic [UW-1:0]  um1_reg, um2_reg;
    logic           ng1_reg, ng2_reg, ng3_reg;
    logic [DW-1:0]  dn1_reg, dn2_reg, dn3_reg;
    logic [64:0]    plo_reg;
    logic [41:0]    phi_reg;
    logic [74:0]    mag_sum;
    logic [IW-1:0]  mag;
    logic signed [IW-1:0] integral_reg;

    always_comb
    begin
        h_sel   = side_m[0] ? HQW'(hs_m) : hq[HQW];
        s_sum   = 43'(fd_m[FW_F+DW-1:DW]) + 43'(h_sel) * 43'd3;
        mag_sum = (75'(phi_reg) << 32) + 75'(plo_reg) + 75'(32'h4000_0000);
        mag     = IW'(mag_sum >> 31);
    end

    always_ff @(posedge clk)
    begin
        s_reg        <= s_sum[42:2];
        um1_reg      <= side_m[SIDEW-1:2];
        ng1_reg      <= side_m[1];
        dn1_reg      <= fd_m[DW-1:0];
        plo_reg      <= 65'(um1_reg) * 65'(s_reg[31:0]);
        phi_reg      <= 42'(um1_reg) * 42'(s_reg[40:32]);
        um2_reg      <= um1_reg;
        ng2_reg      <= ng1_reg;
        dn2_reg      <= dn1_reg;
        integral_reg <= ng2_reg ? -$signed(mag) : $signed(mag);
        ng3_reg      <= ng2_reg;
        dn3_reg      <= dn2_reg;
    end

    assign result.integral = integral_reg;
    assign result.density  = dn3_reg;

    logic unused_ok;
    assign unused_ok = ^{um2_reg, ng3_reg, wr[WQW], wdv[WQW], wf[WQW], hr[HQW], hdv[HQW],
                         hf[HQW], cx[ATAN_STAGES], cy[ATAN_STAGES]};
endmodule

### src/cubic_lorentzian_density_integral.sv
// Top level of the cubed-Lorentzian density and integral block.
// Depends on clci_pkg and clci_lane (two lanes: upper and lower offset).
//
//   channel   signals                                  direction
//   request   start, busy, func, x_value               in (busy out)
//   result    done, value, saturated                   out
//   config    cfg_valid, cfg_ready, cfg_index, cfg_data in (cfg_ready out)
//
// One request per cycle while busy is low; results come back in request order.
// The latency is set by the CORDIC row, the 40-cell divider for atan(t)/t and the
// multiply stages around them; the w divider row runs beside the CORDIC row.
// Reset sets busy high; it clears once reset is released. The receiver cannot stall; done lasts one cycle.
module cubic_lorentzian_density_integral
    import clci_pkg::*;
#(
    parameter int ATAN_STAGES = 24
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  func,
    input  logic [31:0] x_value,
    output logic        done,
    output logic [31:0] value,
    output logic        saturated,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    localparam int LAT = ATAN_STAGES + 46;
    localparam logic signed [IW:0] VMAX = (IW+1)'(64'sd2147483647);
    localparam logic signed [IW:0] VMIN = (IW+1)'(-64'sd2147483648);

    logic [31:0] center_reg, scale_k_reg, range_low_reg, range_high_reg;
    logic        busy_reg;

    assign cfg_ready = 1'b1;
    assign busy      = busy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg       <= 1'b1;
            center_reg     <= '0;
            scale_k_reg    <= SCALE_K_RESET;
            range_low_reg  <= '0;
            range_high_reg <= '0;
        end
        else
        begin
            busy_reg <= 1'b0;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    REG_CENTER:     center_reg     <= cfg_data;
                    REG_SCALE_K:    scale_k_reg    <= cfg_data;
                    REG_RANGE_LOW:  range_low_reg  <= cfg_data;
                    REG_RANGE_HIGH: range_high_reg <= cfg_data;
                endcase
            end
        end
    end

    // request stage
    logic                 accept;
    logic                 vld_reg;
    logic [1:0]           func_reg;
    logic signed [UW-1:0] ua_reg, ua_next;
    logic signed [UW-1:0] ub_reg, ub_next;
    logic [UW-1:0]        cext;

    always_comb
    begin
        accept  = start && !busy_reg;
        cext    = {center_reg[31], center_reg};
        ua_next = (func_t'(func) == FUNC_RANGE)
                  ? $signed({range_high_reg[31], range_high_reg} - cext)
                  : $signed({x_value[31], x_value} - cext);
        ub_next = $signed({range_low_reg[31], range_low_reg} - cext);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg <= func;
        ua_reg   <= ua_next;
        ub_reg   <= ub_next;
    end

    lane_out_t lane_a, lane_b;

    clci_lane #(.ATAN_STAGES(ATAN_STAGES)) u_lane_a (
        .clk     (clk),
        .u       (ua_reg),
        .scale_k (scale_k_reg),
        .result  (lane_a)
    );

    clci_lane #(.ATAN_STAGES(ATAN_STAGES)) u_lane_b (
        .clk     (clk),
        .u       (ub_reg),
        .scale_k (scale_k_reg),
        .result  (lane_b)
    );

    // hold selector and valid beside the lanes
    logic       vpipe_reg [LAT];
    logic [1:0] fpipe_reg [LAT];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LAT; i++)
            begin
                vpipe_reg[i] <= 1'b0;
            end
        end
        else
        begin
            vpipe_reg[0] <= vld_reg;
            for (int i = 1; i < LAT; i++)
            begin
                vpipe_reg[i] <= vpipe_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        fpipe_reg[0] <= func_reg;
        for (int i = 1; i < LAT; i++)
        begin
            fpipe_reg[i] <= fpipe_reg[i-1];
        end
    end

    // select, saturate
    logic signed [IW:0] res;
    logic [31:0]        value_reg, value_next;
    logic               sat_reg, sat_next;
    logic               done_reg;

    always_comb
    begin
        unique case (func_t'(fpipe_reg[LAT-1]))
            FUNC_DENSITY:  res = $signed((IW+1)'(lane_a.density));
            FUNC_INTEGRAL: res = (IW+1)'(lane_a.integral);
            FUNC_RANGE:    res = (IW+1)'(lane_a.integral) - (IW+1)'(lane_b.integral);
            default:       res = '0;
        endcase
        if (res > VMAX)
        begin
            value_next = 32'h7FFF_FFFF;
            sat_next   = 1'b1;
        end
        else if (res < VMIN)
        begin
            value_next = 32'h8000_0000;
            sat_next   = 1'b1;
        end
        else
        begin
            value_next = res[31:0];
            sat_next   = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= vpipe_reg[LAT-1];
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        sat_reg   <= sat_next;
    end

    assign done      = done_reg;
    assign value     = value_reg;
    assign saturated = sat_reg;
endmodule

### src/clci_checker.sv
// Port-level checks of the cubed-Lorentzian block, attached by bind.
// Depends on clci_pkg and the top level cubic_lorentzian_density_integral.
module clci_checker
    import clci_pkg::*;
#(
    parameter int ATAN_STAGES = 24
) (
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic [1:0]  func,
    input logic        done,
    input logic [31:0] value,
    input logic        saturated
);
    localparam int RLAT = ATAN_STAGES + 48;

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##RLAT done)
        else $error("request without result");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, RLAT))
        else $error("result without request");

    a_sat_value: assert property (@(posedge clk) disable iff (!rst_n)
        (done && saturated) |-> (value == 32'h7FFF_FFFF || value == 32'h8000_0000))
        else $error("saturated result not at a limit");

    a_density_unsat: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && func == FUNC_DENSITY) |-> ##RLAT !saturated)
        else $error("density flagged saturated");
endmodule

bind cubic_lorentzian_density_integral clci_checker #(.ATAN_STAGES(ATAN_STAGES)) u_clci_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .func      (func),
    .done      (done),
    .value     (value),
    .saturated (saturated)
);

### sim/tb_cubic_lorentzian_density_integral.sv
`timescale 1ns / 1ps
// Testbench for cubic_lorentzian_density_integral: directed table, then random register settings and requests.
// Depends on clci_pkg and the block; results are checked against table values or a local fixed-point predictor.
module tb_cubic_lorentzian_density_integral;
    import clci_pkg::*;

    localparam int LATENCY = 24 + 47;
    localparam int WATCHDOG_LIMIT = 4000;

    typedef enum logic { ROW_REQ, ROW_CFG } row_kind_t;

    typedef struct {
        row_kind_t   kind;
        logic [1:0]  sel;
        logic [31:0] data;
        logic        typed;
        logic [31:0] exp_value;
        logic        exp_sat;
    } row_t;

    typedef struct {
        logic [31:0] value;
        logic        sat;
    } profile_result_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  func;
    logic [31:0] x_value;
    logic        done;
    logic [31:0] value;
    logic        saturated;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_data;

    logic [31:0] m_center;
    logic [31:0] m_scale;
    logic [31:0] m_lo;
    logic [31:0] m_hi;

    profile_result_t pending_results[$];
    int error_count;
    int idle_cycles;
    bit no_gaps;

    cubic_lorentzian_density_integral dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .func(func),
        .x_value(x_value), .done(done), .value(value), .saturated(saturated),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    function automatic void queue_expected(profile_result_t r);
        pending_results.insert(pending_results.size(), r);
    endfunction

    function automatic longint unsigned offset_to_t(longint unsigned umag);
        longint unsigned lo_part;
        longint unsigned hi_part;
        lo_part = umag * (m_scale & 32'hFFFF);
        hi_part = umag * (m_scale >> 16);
        return (hi_part << 8) + (lo_part >> 8);
    endfunction

    function automatic longint unsigned square_q32(longint unsigned t);
        longint unsigned th;
        longint unsigned tl;
        th = t >> 32;
        tl = t & 64'hFFFF_FFFF;
        return ((th * th) << 32) + 2 * th * tl + ((tl * tl) >> 32);
    endfunction

    function automatic longint unsigned recip_w(longint unsigned t);
        if (t >= (64'd1 << 47))
        begin
            return 0;
        end
        return (64'd1 << 62) / ((64'd1 << 32) + square_q32(t));
    endfunction

    function automatic longint unsigned cordic_atan(longint unsigned t);
        longint cx;
        longint cy;
        longint cz;
        longint dx;
        longint dy;
        longint ang;
        cx = longint'(64'd1 << 32);
        cy = longint'(t);
        cz = 0;
        for (int i = 0; i < 24; i++)
        begin
            ang = (i <= 10) ? longint'(ATAN_TAB[i]) : longint'((64'd1 << 30) >> i);
            dx = cy >>> i;
            dy = cx >>> i;
            if (cy > 0)
            begin
                cx += dx;
                cy -= dy;
                cz += ang;
            end
            else
            begin
                cx -= dx;
                cy += dy;
                cz -= ang;
            end
        end
        return (cz < 0) ? 0 : longint'(cz);
    endfunction

    function automatic longint profile_integral(longint u);
        longint unsigned umag;
        longint unsigned t;
        longint unsigned w;
        longint unsigned f;
        longint unsigned h;
        longint unsigned s;
        longint unsigned mag;
        umag = (u < 0) ? longint'(-u) : longint'(u);
        t = offset_to_t(umag);
        w = recip_w(t);
        f = 3 * w + ((2 * w * w) >> 30);
        if (t < (64'd1 << 24))
        begin
            h = (64'd1 << 30) - (square_q32(t) >> 2) / 3;
        end
        else
        begin
            h = (cordic_atan(t) << 32) / t;
        end
        s = (f + 3 * h) >> 2;
        mag = (umag * s + (64'd1 << 30)) >> 31;
        return (u < 0) ? -longint'(mag) : longint'(mag);
    endfunction

    function automatic profile_result_t clip_result(longint v);
        profile_result_t r;
        r.sat = 1'b0;
        if (v > 64'sd2147483647)
        begin
            v = 64'sd2147483647;
            r.sat = 1'b1;
        end
        if (v < -64'sd2147483648)
        begin
            v = -64'sd2147483648;
            r.sat = 1'b1;
        end
        r.value = v[31:0];
        return r;
    endfunction

    function automatic profile_result_t predict_profile(logic [1:0] sel, logic [31:0] x);
        profile_result_t r;
        longint c;
        longint u;
        longint unsigned umag;
        longint unsigned w;
        longint unsigned w3;
        c = longint'(signed'(m_center));
        r.value = 32'd0;
        r.sat = 1'b0;
        case (sel)
            FUNC_DENSITY:
            begin
                u = longint'(signed'(x)) - c;
                umag = (u < 0) ? longint'(-u) : longint'(u);
                w = recip_w(offset_to_t(umag));
                w3 = (((w * w) >> 30) * w) >> 30;
                r = clip_result(longint'((w3 + (64'd1 << 13)) >> 14));
            end
            FUNC_INTEGRAL:
            begin
                r = clip_result(profile_integral(longint'(signed'(x)) - c));
            end
            FUNC_RANGE:
            begin
                r = clip_result(profile_integral(longint'(signed'(m_hi)) - c)
                    - profile_integral(longint'(signed'(m_lo)) - c));
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("%0t mismatch %s: got %h want %h", $realtime, what, got, want);
        error_count++;
    endtask

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(99);
        if (no_gaps || roll < 60)
        begin
            return 0;
        end
        if (roll < 92)
        begin
            return $urandom_range(3, 1);
        end
        return $urandom_range(40, 10);
    endfunction

    always @(posedge clk)
    begin
        if (done)
        begin
            if (pending_results.size() == 0)
            begin
                report_mismatch("unexpected result", value, 32'd0);
            end
            else
            begin
                if (value !== pending_results[0].value)
                begin
                    report_mismatch("value", value, pending_results[0].value);
                end
                if (saturated !== pending_results[0].sat)
                begin
                    report_mismatch("saturated", {31'd0, saturated},
                        {31'd0, pending_results[0].sat});
                end
                void'(pending_results.pop_front());
            end
        end
    end

    always @(posedge clk)
    begin
        if ((start && !busy) || done || (cfg_valid && cfg_ready))
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb_cubic_lorentzian_density_integral: errors");
            $finish;
        end
    end

    task automatic drain_results();
        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (LATENCY + 8) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] data);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        forever
        begin
            @(negedge clk);
            if (cfg_ready)
            begin
                break;
            end
        end
        @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            REG_CENTER:     m_center = data;
            REG_SCALE_K:    m_scale  = data;
            REG_RANGE_LOW:  m_lo     = data;
            default:        m_hi     = data;
        endcase
    endtask

    task automatic issue_request(logic [1:0] sel, logic [31:0] x, logic typed,
                                 logic [31:0] exp_value, logic exp_sat);
        profile_result_t r;
        int gap;
        if (typed)
        begin
            r.value = exp_value;
            r.sat = exp_sat;
        end
        else
        begin
            r = predict_profile(sel, x);
        end
        queue_expected(r);
        start   <= 1'b1;
        func    <= sel;
        x_value <= x;
        forever
        begin
            @(negedge clk);
            if (!busy)
            begin
                break;
            end
        end
        @(posedge clk);
        gap = pick_gap();
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    function automatic logic [31:0] pick_edge_word();
        case ($urandom_range(3))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h0000_0000;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] pick_scale();
        case ($urandom_range(5))
            0:       return 32'hFFFF_FFFF;
            1:       return 32'h0000_0001;
            2:       return SCALE_K_RESET;
            3:       return $urandom_range(32'h0400_0000, 32'h0010_0000);
            4:       return $urandom_range(32'h0000_FFFF);
            default: return $urandom;
        endcase
    endfunction

    row_t directed[$];

    function automatic void add_row(row_t r);
        directed.insert(directed.size(), r);
    endfunction

    function automatic row_t mk(row_kind_t kind, logic [1:0] sel, logic [31:0] data,
                                logic typed, logic [31:0] ev, logic es);
        row_t r;
        r.kind = kind;
        r.sel = sel;
        r.data = data;
        r.typed = typed;
        r.exp_value = ev;
        r.exp_sat = es;
        return r;
    endfunction

    initial
    begin
        logic [1:0]  sel;
        logic [31:0] x;
        int span;
        error_count = 0;
        idle_cycles = 0;
        no_gaps = 1'b0;
        rst_n = 1'b0;
        start = 1'b0;
        func = FUNC_DENSITY;
        x_value = 32'd0;
        cfg_valid = 1'b0;
        cfg_index = REG_CENTER;
        cfg_data = 32'd0;
        m_center = 32'd0;
        m_scale = SCALE_K_RESET;
        m_lo = 32'd0;
        m_hi = 32'd0;

        add_row(mk(ROW_REQ, FUNC_DENSITY, 32'h0, 1, 32'h0001_0000, 0));
        add_row(mk(ROW_REQ, 2'd3, 32'hFFFF_FFFF, 1, 32'h0, 0));
        add_row(mk(ROW_REQ, FUNC_RANGE, 32'h1234_5678, 1, 32'h0, 0));
        add_row(mk(ROW_REQ, FUNC_INTEGRAL, 32'h0, 1, 32'h0, 0));
        add_row(mk(ROW_REQ, FUNC_DENSITY, 32'h7FFF_FFFF, 0, 0, 0));
        add_row(mk(ROW_REQ, FUNC_DENSITY, 32'h8000_0000, 0, 0, 0));
        add_row(mk(ROW_REQ, FUNC_DENSITY, 32'hFFFF_0000, 0, 0, 0));
        add_row(mk(ROW_REQ, FUNC_INTEGRAL, 32'h7FFF_FFFF, 0, 0, 0));
        add_row(mk(ROW_REQ, FUNC_INTEGRAL, 32'h8000_0000, 0, 0, 0));
        add_row(mk(ROW_REQ, FUNC_INTEGRAL, 32'h0001_0000, 0, 0, 0));
        add_row(mk(ROW_REQ, FUNC_INTEGRAL, 32'h0000_0001, 0, 0, 0));
        add_row(mk(ROW_CFG, REG_SCALE_K, 32'h0, 0, 0, 0));
        add_row(mk(ROW_CFG, REG_CENTER, 32'h8000_0000, 0, 0, 0));
        add_row(mk(ROW_REQ, FUNC_INTEGRAL, 32'h7FFF_FFFF, 1, 32'h7FFF_FFFF, 1));
        add_row(mk(ROW_REQ, FUNC_DENSITY, 32'h7FFF_FFFF, 1, 32'h0001_0000, 0));
        add_row(mk(ROW_CFG, REG_CENTER, 32'h7FFF_FFFF, 0, 0, 0));
        add_row(mk(ROW_REQ, FUNC_INTEGRAL, 32'h8000_0000, 1, 32'h8000_0000, 1));
        add_row(mk(ROW_CFG, REG_CENTER, 32'h0, 0, 0, 0));
        add_row(mk(ROW_CFG, REG_RANGE_HIGH, 32'h7FFF_FFFF, 0, 0, 0));
        add_row(mk(ROW_CFG, REG_RANGE_LOW, 32'h8000_0000, 0, 0, 0));
        add_row(mk(ROW_REQ, FUNC_RANGE, 32'h0, 1, 32'h7FFF_FFFF, 1));
        add_row(mk(ROW_CFG, REG_SCALE_K, 32'hFFFF_FFFF, 0, 0, 0));
        add_row(mk(ROW_REQ, FUNC_RANGE, 32'h0, 0, 0, 0));
        add_row(mk(ROW_CFG, REG_RANGE_LOW, 32'h0002_0000, 0, 0, 0));
        add_row(mk(ROW_REQ, FUNC_RANGE, 32'h0, 0, 0, 0));
        add_row(mk(ROW_REQ, FUNC_INTEGRAL, 32'h0000_0100, 0, 0, 0));

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
        begin
            if (directed[i].kind == ROW_CFG)
            begin
                start <= 1'b0;
                write_reg(directed[i].sel, directed[i].data);
            end
            else
            begin
                issue_request(directed[i].sel, directed[i].data, directed[i].typed,
                    directed[i].exp_value, directed[i].exp_sat);
            end
        end

        for (int phase = 0; phase < 8; phase++)
        begin
            start <= 1'b0;
            write_reg(REG_CENTER, (phase % 2) ? pick_edge_word() : $urandom);
            write_reg(REG_SCALE_K, pick_scale());
            write_reg(REG_RANGE_LOW, pick_edge_word());
            write_reg(REG_RANGE_HIGH, $urandom_range(1) ? pick_edge_word()
                : m_center + $urandom_range(32'h0008_0000));
            no_gaps = (phase % 3 == 2);
            span = $urandom_range(24, 4);
            for (int n = 0; n < 80; n++)
            begin
                sel = ($urandom_range(19) == 0) ? 2'd3 : 2'($urandom_range(2));
                if ($urandom_range(1))
                begin
                    x = m_center + 32'($signed($urandom) >>> (32 - span));
                end
                else
                begin
                    x = $urandom;
                end
                issue_request(sel, x, 0, 0, 0);
            end
        end

        start <= 1'b0;
        drain_results();
        if (error_count == 0)
        begin
            $display("tb_cubic_lorentzian_density_integral: clean");
        end
        else
        begin
            $display("tb_cubic_lorentzian_density_integral: errors");
        end
        $finish;
    end

endmodule
